// ===== rtl/core/tnp_pkg.sv =====
`timescale 1ns / 1ps

package tnp_pkg;

  // Telnet command bytes
  localparam logic [7:0] TN_IAC  = 8'hFF;
  localparam logic [7:0] TN_WILL = 8'hFB;
  localparam logic [7:0] TN_WONT = 8'hFC;
  localparam logic [7:0] TN_DO   = 8'hFD;
  localparam logic [7:0] TN_DONT = 8'hFE;
  localparam logic [7:0] TN_SB   = 8'hFA;
  localparam logic [7:0] TN_SE   = 8'hF0;

  // Options this side knows
  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;
  localparam logic [7:0] OPT_NAWS = 8'd31;

  // Result kinds on the output
  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_REPLY  = 3'd1;
  localparam logic [2:0] KIND_WSIZE  = 3'd2;
  localparam logic [2:0] KIND_DISC   = 3'd3;
  localparam logic [2:0] KIND_AGREED = 3'd4;

  // Job codes passed from the parser to the emitter
  localparam logic [2:0] JOB_DATA  = 3'd0;
  localparam logic [2:0] JOB_DENY  = 3'd1;
  localparam logic [2:0] JOB_WSIZE = 3'd2;
  localparam logic [2:0] JOB_DISC  = 3'd3;
  localparam logic [2:0] JOB_AGREE = 3'd4;

  // One job: expands to one result, or three for a denial
  typedef struct packed {
    logic [2:0]  code;
    logic [7:0]  value;   // data byte or option code
    logic [7:0]  cmd;     // deny command byte
    logic [15:0] width;
    logic [15:0] height;
  } job_t;

endpackage

// ===== rtl/core/telnet_option_stream_parser.sv =====
`timescale 1ns / 1ps

// Channel   Handshake          Payload
// input     push / full        rx_byte
// result    empty / pop        out_kind, out_value, window_width, window_height,
//                              last_of_run
//
// One byte is accepted per cycle while the job queue has room; a result
// passes through the job queue and then the output register.
// A denial takes three result beats from the emitter, but it comes from a
// three-byte command, so with pop held high the input never stalls; the
// lag a denial adds to later results is absorbed by the queue.
// rst is synchronous: parser back to DATA, queue and output register empty.
// A stalled pop holds the result register; the parser keeps taking bytes
// until the QUEUE_DEPTH-entry job queue is full.

module telnet_option_stream_parser
  import tnp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [15:0] window_width,
  output logic [15:0] window_height,
  output logic        last_of_run
);

  logic accept;
  logic new_valid;
  job_t new_job;
  job_t head_job;
  logic head_avail;
  logic head_done;

  assign accept = push && !full;

  // Byte parser
  tnp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .job_valid (new_valid),
    .job       (new_job)
  );

  // Job queue between parser and emitter
  tnp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && new_valid),
    .wr_data  (new_job),
    .rd_en    (head_done),
    .rd_data  (head_job),
    .nonempty (head_avail),
    .full     (full)
  );

  // Result emitter
  tnp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_avail     (head_avail),
    .job           (head_job),
    .job_done      (head_done),
    .pop           (pop),
    .empty         (empty),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .window_width  (window_width),
    .window_height (window_height),
    .last_of_run   (last_of_run)
  );

endmodule

// ===== rtl/core/tnp_front.sv =====
`timescale 1ns / 1ps

module tnp_front
  import tnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       job_valid,
  output job_t       job
);

  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_IAC     = 3'd1;
  localparam logic [2:0] ST_COMMAND = 3'd2;
  localparam logic [2:0] ST_SB      = 3'd3;
  localparam logic [2:0] ST_SBDATA  = 3'd4;
  localparam logic [2:0] ST_SBIAC   = 3'd5;

  logic [2:0] state, state_next;
  logic [7:0] pending_command, pending_command_next;
  logic [7:0] sub_option, sub_option_next;
  logic [2:0] sub_count, sub_count_next;
  logic [7:0] sub_bytes [4];
  logic       sub_wr;
  logic       sub_push;
  logic [7:0] allow_cmd;
  logic [7:0] deny_cmd;
  logic [7:0] ours_cmd;
  logic       known_opt;

  // Reply that would agree with the peer, and the denial
  always_comb begin
    unique case (pending_command)
      TN_WILL: begin allow_cmd = TN_DO;   deny_cmd = TN_DONT; end
      TN_DO:   begin allow_cmd = TN_WILL; deny_cmd = TN_WONT; end
      TN_WONT: begin allow_cmd = TN_DONT; deny_cmd = TN_DO;   end
      TN_DONT: begin allow_cmd = TN_WONT; deny_cmd = TN_WILL; end
      default: begin allow_cmd = 8'd0;    deny_cmd = 8'd0;    end
    endcase
  end

  // Fixed option table
  always_comb begin
    unique case (rx_byte)
      OPT_ECHO: begin known_opt = 1'b1; ours_cmd = TN_WILL; end
      OPT_SGA:  begin known_opt = 1'b1; ours_cmd = TN_WILL; end
      OPT_NAWS: begin known_opt = 1'b1; ours_cmd = TN_DO;   end
      default:  begin known_opt = 1'b0; ours_cmd = 8'd0;    end
    endcase
  end

  // Parser state machine and job classification
  always_comb begin
    state_next           = state;
    pending_command_next = pending_command;
    sub_option_next      = sub_option;
    sub_push             = 1'b0;
    job_valid            = 1'b0;
    job                  = '0;
    sub_count_next       = sub_count;
    unique case (state)
      ST_IAC: begin
        if (rx_byte == TN_WILL || rx_byte == TN_WONT ||
            rx_byte == TN_DO || rx_byte == TN_DONT) begin
          state_next           = ST_COMMAND;
          pending_command_next = rx_byte;
        end else if (rx_byte == TN_SB) begin
          state_next = ST_SB;
        end else if (rx_byte == TN_IAC) begin
          state_next = ST_DATA;
          job_valid  = 1'b1;
          job.code   = JOB_DATA;
          job.value  = rx_byte;
        end else begin
          state_next = ST_DATA;
        end
      end
      ST_COMMAND: begin
        state_next = ST_DATA;
        job_valid  = 1'b1;
        job.value  = rx_byte;
        if (!known_opt) begin
          job.code = JOB_DENY;
          job.cmd  = deny_cmd;
        end else if (ours_cmd != allow_cmd) begin
          job.code  = JOB_DISC;
          job.value = 8'd0;
        end else begin
          job.code = JOB_AGREE;
        end
      end
      ST_SB: begin
        sub_option_next = rx_byte;
        state_next      = ST_SBDATA;
      end
      ST_SBDATA: begin
        if (rx_byte == TN_IAC) begin
          state_next = ST_SBIAC;
        end else begin
          sub_push = 1'b1;
        end
      end
      ST_SBIAC: begin
        if (rx_byte == TN_SE) begin
          state_next     = ST_DATA;
          sub_count_next = 3'd0;
          if (sub_count == 3'd4 && sub_option == OPT_NAWS) begin
            job_valid  = 1'b1;
            job.code   = JOB_WSIZE;
            job.width  = {sub_bytes[0], sub_bytes[1]};
            job.height = {sub_bytes[2], sub_bytes[3]};
          end
        end else if (rx_byte == TN_IAC) begin
          sub_push   = 1'b1;
          state_next = ST_SBDATA;
        end else begin
          state_next = ST_DATA;
        end
      end
      default: begin
        // DATA and unused encodings
        if (rx_byte == TN_IAC) begin
          state_next = ST_IAC;
        end else begin
          state_next = ST_DATA;
          job_valid  = 1'b1;
          job.code   = JOB_DATA;
          job.value  = rx_byte;
        end
      end
    endcase
    // Saturating buffer count, first four bytes kept
    sub_wr = sub_push && !sub_count[2];
    if (sub_push && sub_count != 3'd7) begin
      sub_count_next = sub_count + 3'd1;
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_DATA;
      pending_command <= 8'd0;
      sub_option      <= 8'd0;
      sub_count       <= 3'd0;
    end else if (accept) begin
      state           <= state_next;
      pending_command <= pending_command_next;
      sub_option      <= sub_option_next;
      sub_count       <= sub_count_next;
    end
  end

  // Subnegotiation buffer
  always_ff @(posedge clk) begin
    if (accept && sub_wr) begin
      sub_bytes[sub_count[1:0]] <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/tnp_fifo.sv =====
`timescale 1ns / 1ps

module tnp_fifo
  import tnp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  input  logic rd_en,
  output job_t rd_data,
  output logic nonempty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rd_data  = mem[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count == CNT_W'(DEPTH));

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/tnp_back.sv =====
`timescale 1ns / 1ps

module tnp_back
  import tnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_avail,
  input  job_t        job,
  output logic        job_done,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [15:0] window_width,
  output logic [15:0] window_height,
  output logic        last_of_run
);

  logic       out_valid;
  logic [1:0] beat;
  logic       load;
  logic       last_beat;
  logic [2:0] kind_next;
  logic [7:0] value_next;

  assign empty     = !out_valid;
  assign load      = job_avail && (!out_valid || pop);
  assign last_beat = (job.code != JOB_DENY) || (beat == 2'd2);
  assign job_done  = load && last_beat;

  // Result beat for the head job
  always_comb begin
    unique case (job.code)
      JOB_DENY: begin
        kind_next = KIND_REPLY;
        case (beat)
          2'd0:    value_next = TN_IAC;
          2'd1:    value_next = job.cmd;
          default: value_next = job.value;
        endcase
      end
      JOB_WSIZE: begin kind_next = KIND_WSIZE;  value_next = 8'd0;      end
      JOB_DISC:  begin kind_next = KIND_DISC;   value_next = 8'd0;      end
      JOB_AGREE: begin kind_next = KIND_AGREED; value_next = job.value; end
      default:   begin kind_next = KIND_DATA;   value_next = job.value; end
    endcase
  end

  // Output valid and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat      <= last_beat ? 2'd0 : beat + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind      <= kind_next;
      out_value     <= value_next;
      window_width  <= (job.code == JOB_WSIZE) ? job.width : 16'd0;
      window_height <= (job.code == JOB_WSIZE) ? job.height : 16'd0;
      last_of_run   <= last_beat;
    end
  end

endmodule

// ===== rtl/core/tnp_checker.sv =====
`timescale 1ns / 1ps

module tnp_checker
  import tnp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_value,
  input logic [15:0] window_width,
  input logic [15:0] window_height,
  input logic        last_of_run
);

  // Nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // A result not taken stays as it is
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_value) &&
                          $stable(last_of_run)))
    else $error("result changed while stalled");

  // Only reply beats may be non-final
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind != KIND_REPLY) |-> last_of_run)
    else $error("single-beat result without last_of_run");

  // Window size fields are zero outside a window-size beat
  a_wsize_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind != KIND_WSIZE) |-> (window_width == 16'd0 &&
                                            window_height == 16'd0))
    else $error("window size on a non-window beat");

  // A denial opens with IAC
  a_deny_iac: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_kind == KIND_REPLY && last_of_run) |=>
      !(!empty && out_kind == KIND_REPLY && !last_of_run && out_value != TN_IAC &&
        $past(last_of_run)))
    else $error("reply burst does not open with IAC");

endmodule

bind telnet_option_stream_parser tnp_checker u_tnp_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .out_kind      (out_kind),
  .out_value     (out_value),
  .window_width  (window_width),
  .window_height (window_height),
  .last_of_run   (last_of_run)
);
